>>> design/pscrt_pkg.sv
// shared constants, register codes and a helper function for the point placement pipeline
package pscrt_pkg;

    typedef enum logic [2:0] {
        REG_ORIGIN_XY     = 3'd0,
        REG_ORIGIN_Z_SX   = 3'd1,
        REG_SCALE_YZ      = 3'd2,
        REG_SHIFT_XY      = 3'd3,
        REG_SHIFT_Z_QW    = 3'd4,
        REG_QUAT_XY       = 3'd5,
        REG_QUAT_Z_ROT    = 3'd6
    } t_reg_idx;

    localparam int NUM_REGS = 7;

    typedef logic [63:0] t_reg_word;
    typedef t_reg_word t_reg_file [NUM_REGS];

    localparam t_reg_file REG_RESET = '{
        64'h0000000000000000,
        64'h3F80000000000000,
        64'h3F8000003F800000,
        64'h0000000000000000,
        64'h3F80000000000000,
        64'h0000000000000000,
        64'h0000000000000000
    };

    localparam logic [63:0] QZ_ROT_MASK = 64'h00000001FFFFFFFF;

    // single precision bit patterns
    localparam logic [31:0] FP_QNAN = 32'h7FC00000;
    localparam logic [31:0] FP_TWO  = 32'h40000000;

    // unit latency of every adder and multiplier
    localparam int UNIT_LAT = 3;

    // leading zero count of a 48 bit word, 48 when all zero
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] cnt;
        cnt = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                cnt = 6'(47 - i);
            end
        end
        return cnt;
    endfunction

endpackage

>>> design/pscrt_fmul.sv
// three stage single precision multiplier, round to nearest even, subnormals kept
module pscrt_fmul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);
    import pscrt_pkg::*;

    // stage 1: unpack and mantissa product
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] a_man, b_man;
    logic [10:0] a_exp, b_exp;
    logic        n_s1_nan, n_s1_inf, n_s1_zero, n_s1_sign;
    logic [47:0] n_s1_prod;
    logic signed [10:0] n_s1_exp;
    logic        r_s1_nan, r_s1_inf, r_s1_zero, r_s1_sign;
    logic [47:0] r_s1_prod;
    logic signed [10:0] r_s1_exp;

    always_comb begin
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        a_man  = {(i_a[30:23] != 8'd0), i_a[22:0]};
        b_man  = {(i_b[30:23] != 8'd0), i_b[22:0]};
        a_exp  = (i_a[30:23] == 8'd0) ? 11'd1 : {3'd0, i_a[30:23]};
        b_exp  = (i_b[30:23] == 8'd0) ? 11'd1 : {3'd0, i_b[30:23]};
        n_s1_nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
        n_s1_inf  = a_inf || b_inf;
        n_s1_zero = a_zero || b_zero;
        n_s1_sign = i_a[31] ^ i_b[31];
        n_s1_prod = a_man * b_man;
        n_s1_exp  = $signed(a_exp) + $signed(b_exp) - 11'sd126;
    end

    always_ff @(posedge i_clk) begin
        r_s1_nan  <= n_s1_nan;
        r_s1_inf  <= n_s1_inf;
        r_s1_zero <= n_s1_zero;
        r_s1_sign <= n_s1_sign;
        r_s1_prod <= n_s1_prod;
        r_s1_exp  <= n_s1_exp;
    end

    // stage 2: normalize the leading one to the top
    logic [5:0]  lz;
    logic [47:0] n_s2_prod;
    logic signed [10:0] n_s2_exp;
    logic        r_s2_nan, r_s2_inf, r_s2_zero, r_s2_sign;
    logic [47:0] r_s2_prod;
    logic signed [10:0] r_s2_exp;

    always_comb begin
        lz        = lzc48(r_s1_prod);
        n_s2_prod = r_s1_prod << lz;
        n_s2_exp  = r_s1_exp - $signed({5'd0, lz});
    end

    always_ff @(posedge i_clk) begin
        r_s2_nan  <= r_s1_nan;
        r_s2_inf  <= r_s1_inf;
        r_s2_zero <= r_s1_zero;
        r_s2_sign <= r_s1_sign;
        r_s2_prod <= n_s2_prod;
        r_s2_exp  <= n_s2_exp;
    end

    // stage 3: denormalize, round, pack
    logic signed [10:0] dn;
    logic [5:0]  rs;
    logic [10:0] e_fin;
    logic [95:0] wide;
    logic [23:0] man;
    logic        grd, stk, inc;
    logic [24:0] man_r;
    logic [33:0] packed_v;
    logic        ovf;
    logic [31:0] n_y;
    logic [31:0] r_y;

    always_comb begin
        dn = 11'sd1 - r_s2_exp;
        if (r_s2_exp < 11'sd1) begin
            rs    = (dn > 11'sd63) ? 6'd63 : dn[5:0];
            e_fin = 11'd1;
        end else begin
            rs    = 6'd0;
            e_fin = r_s2_exp;
        end
        wide     = {r_s2_prod, 48'd0} >> rs;
        man      = wide[95:72];
        grd      = wide[71];
        stk      = |wide[70:0];
        inc      = grd && (stk || man[0]);
        man_r    = {1'b0, man} + {24'd0, inc};
        packed_v = {e_fin - 11'd1, 23'd0} + {9'd0, man_r};
        ovf      = packed_v >= {11'd255, 23'd0};
        if (r_s2_nan) begin
            n_y = FP_QNAN;
        end else if (r_s2_inf) begin
            n_y = {r_s2_sign, 8'hFF, 23'd0};
        end else if (r_s2_zero) begin
            n_y = {r_s2_sign, 31'd0};
        end else if (ovf) begin
            n_y = {r_s2_sign, 8'hFF, 23'd0};
        end else begin
            n_y = {r_s2_sign, packed_v[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;

endmodule

>>> design/pscrt_fadd.sv
// three stage single precision adder, round to nearest even, subnormals kept
module pscrt_fadd (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);
    import pscrt_pkg::*;

    // stage 1: unpack, order by magnitude, align the smaller operand
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [31:0] big, sml;
    logic [7:0]  big_e, sml_e, diff;
    logic [4:0]  sh;
    logic [58:0] al_wide;
    logic [26:0] n_s1_big, n_s1_sml;
    logic        r_s1_nan, r_s1_inf, r_s1_isgn, r_s1_zsgn, r_s1_sub, r_s1_sign;
    logic [26:0] r_s1_big, r_s1_sml;
    logic [7:0]  r_s1_exp;

    always_comb begin
        a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        swap  = i_b[30:0] > i_a[30:0];
        big   = swap ? i_b : i_a;
        sml   = swap ? i_a : i_b;
        big_e = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        sml_e = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        diff  = big_e - sml_e;
        sh    = (diff > 8'd31) ? 5'd31 : diff[4:0];
        al_wide  = {(sml[30:23] != 8'd0), sml[22:0], 3'd0, 32'd0} >> sh;
        n_s1_big = {(big[30:23] != 8'd0), big[22:0], 3'd0};
        n_s1_sml = {al_wide[58:33], al_wide[32] | (|al_wide[31:0])};
    end

    always_ff @(posedge i_clk) begin
        r_s1_nan  <= a_nan || b_nan || (a_inf && b_inf && (i_a[31] != i_b[31]));
        r_s1_inf  <= a_inf || b_inf;
        r_s1_isgn <= a_inf ? i_a[31] : i_b[31];
        r_s1_zsgn <= i_a[31] && i_b[31];
        r_s1_sub  <= i_a[31] ^ i_b[31];
        r_s1_sign <= big[31];
        r_s1_big  <= n_s1_big;
        r_s1_sml  <= n_s1_sml;
        r_s1_exp  <= big_e;
    end

    // stage 2: add or subtract magnitudes, count leading zeros
    logic [27:0] n_s2_sum;
    logic [5:0]  lz_full;
    logic        r_s2_nan, r_s2_inf, r_s2_isgn, r_s2_zsgn, r_s2_sign;
    logic [27:0] r_s2_sum;
    logic [4:0]  r_s2_lz;
    logic [7:0]  r_s2_exp;

    always_comb begin
        n_s2_sum = r_s1_sub ? ({1'b0, r_s1_big} - {1'b0, r_s1_sml})
                            : ({1'b0, r_s1_big} + {1'b0, r_s1_sml});
        lz_full  = lzc48({n_s2_sum, 20'hFFFFF});
    end

    always_ff @(posedge i_clk) begin
        r_s2_nan  <= r_s1_nan;
        r_s2_inf  <= r_s1_inf;
        r_s2_isgn <= r_s1_isgn;
        r_s2_zsgn <= r_s1_zsgn;
        r_s2_sign <= r_s1_sign;
        r_s2_sum  <= n_s2_sum;
        r_s2_lz   <= lz_full[4:0];
        r_s2_exp  <= r_s1_exp;
    end

    // stage 3: normalize, round, pack
    logic [26:0] norm;
    logic [8:0]  e_fin;
    logic [7:0]  lsh, lim;
    logic [23:0] man;
    logic        grd, stk, inc;
    logic [24:0] man_r;
    logic [32:0] packed_v;
    logic        ovf;
    logic [31:0] n_y;
    logic [31:0] r_y;

    always_comb begin
        lim = r_s2_exp - 8'd1;
        lsh = {3'd0, r_s2_lz} - 8'd1;
        if (r_s2_sum[27]) begin
            norm  = {r_s2_sum[27:2], r_s2_sum[1] | r_s2_sum[0]};
            e_fin = {1'b0, r_s2_exp} + 9'd1;
        end else begin
            if (lsh > lim) begin
                lsh = lim;
            end
            norm  = r_s2_sum[26:0] << lsh;
            e_fin = {1'b0, r_s2_exp} - {1'b0, lsh};
        end
        man      = norm[26:3];
        grd      = norm[2];
        stk      = |norm[1:0];
        inc      = grd && (stk || man[0]);
        man_r    = {1'b0, man} + {24'd0, inc};
        packed_v = {e_fin - 9'd1, 23'd0} + {8'd0, man_r};
        ovf      = packed_v >= {9'd255, 23'd0};
        if (r_s2_nan) begin
            n_y = FP_QNAN;
        end else if (r_s2_inf) begin
            n_y = {r_s2_isgn, 8'hFF, 23'd0};
        end else if (r_s2_sum == 28'd0) begin
            n_y = {r_s2_zsgn, 31'd0};
        end else if (ovf) begin
            n_y = {r_s2_sign, 8'hFF, 23'd0};
        end else begin
            n_y = {r_s2_sign, packed_v[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;

endmodule

>>> design/point_scale_rotate_translate_unit.sv
// top level: origin subtract, per-axis scale, quaternion rotate and translate of 3d points
//
// One point enters per clock: an item is taken at every rising edge with start high and
// busy low, and busy is low at all times except in reset and the cycle right after it.
// Each point leaves on the o_placed_* ports with o_valid high for one cycle; the receiver
// cannot stall, so nothing ever backs up. The path is nine dependent
// single precision operations (subtract, scale, q x v, difference, doubling, products
// with t, two sums, translate), each a three stage adder or multiplier. All 18 adders
// and 21 multipliers are separate units, so the pipeline sustains one point per clock.
// Results are IEEE single, round to nearest even, subnormals kept, any NaN given as
// 0x7FC00000. With rotation off the scaled point goes straight to the translate adder.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data and
// must only change while no point is in flight.
module point_scale_rotate_translate_unit #(
    parameter int TAG_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic [15:0] i_point_tag,
    input  logic        i_batch_end,
    output logic        o_valid,
    output logic [31:0] o_placed_x,
    output logic [31:0] o_placed_y,
    output logic [31:0] o_placed_z,
    output logic [15:0] o_result_tag,
    output logic        o_result_end
);
    import pscrt_pkg::*;

    // tag bits actually kept
    localparam int KEEP = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int LAT  = 9 * UNIT_LAT;
    // v is needed again at the v + w*t adders and at the rotate bypass
    localparam int V_TAP_ADD = 4 * UNIT_LAT - 1;
    localparam int V_TAP_OUT = 6 * UNIT_LAT - 1;

    // configuration registers
    t_reg_file r_cfg;
    logic      r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= REG_RESET;
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ORIGIN_XY:   r_cfg[REG_ORIGIN_XY]   <= i_cfg_data;
                    REG_ORIGIN_Z_SX: r_cfg[REG_ORIGIN_Z_SX] <= i_cfg_data;
                    REG_SCALE_YZ:    r_cfg[REG_SCALE_YZ]    <= i_cfg_data;
                    REG_SHIFT_XY:    r_cfg[REG_SHIFT_XY]    <= i_cfg_data;
                    REG_SHIFT_Z_QW:  r_cfg[REG_SHIFT_Z_QW]  <= i_cfg_data;
                    REG_QUAT_XY:     r_cfg[REG_QUAT_XY]     <= i_cfg_data;
                    REG_QUAT_Z_ROT:  r_cfg[REG_QUAT_Z_ROT]  <= i_cfg_data & QZ_ROT_MASK;
                    default: ;  // out of range index, write dropped
                endcase
            end
        end
    end

    assign busy = ~r_run;

    logic        accept;
    logic [31:0] pnt [3];
    logic [31:0] org [3];
    logic [31:0] scl [3];
    logic [31:0] shf [3];
    logic [31:0] qv  [3];
    logic [31:0] qw;
    logic        rot_en;

    assign accept = start && !busy;
    assign pnt[0] = i_point_x;
    assign pnt[1] = i_point_y;
    assign pnt[2] = i_point_z;
    assign org[0] = r_cfg[REG_ORIGIN_XY][31:0];
    assign org[1] = r_cfg[REG_ORIGIN_XY][63:32];
    assign org[2] = r_cfg[REG_ORIGIN_Z_SX][31:0];
    assign scl[0] = r_cfg[REG_ORIGIN_Z_SX][63:32];
    assign scl[1] = r_cfg[REG_SCALE_YZ][31:0];
    assign scl[2] = r_cfg[REG_SCALE_YZ][63:32];
    assign shf[0] = r_cfg[REG_SHIFT_XY][31:0];
    assign shf[1] = r_cfg[REG_SHIFT_XY][63:32];
    assign shf[2] = r_cfg[REG_SHIFT_Z_QW][31:0];
    assign qw     = r_cfg[REG_SHIFT_Z_QW][63:32];
    assign qv[0]  = r_cfg[REG_QUAT_XY][31:0];
    assign qv[1]  = r_cfg[REG_QUAT_XY][63:32];
    assign qv[2]  = r_cfg[REG_QUAT_Z_ROT][31:0];
    assign rot_en = r_cfg[REG_QUAT_Z_ROT][32];

    // datapath signals, one per axis
    logic [31:0] dif [3];   // p - origin
    logic [31:0] vec [3];   // scaled point v
    logic [31:0] qva [3];
    logic [31:0] qvb [3];
    logic [31:0] crs [3];   // q x v
    logic [31:0] tv  [3];   // t = 2 (q x v)
    logic [31:0] wt  [3];
    logic [31:0] qta [3];
    logic [31:0] qtb [3];
    logic [31:0] sa  [3];   // v + w t
    logic [31:0] sb  [3];   // q x t
    logic [31:0] rv  [3];   // rotated point
    logic [31:0] pre [3];   // rotated or bypassed, before translate
    logic [31:0] res [3];

    // v delay line
    logic [95:0] r_vd [V_TAP_OUT + 1];

    always_ff @(posedge i_clk) begin
        r_vd[0] <= {vec[2], vec[1], vec[0]};
        for (int n = 1; n <= V_TAP_OUT; n++) begin
            r_vd[n] <= r_vd[n - 1];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_axis
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        pscrt_fadd u_sub_org (.i_clk, .i_a(pnt[i]), .i_b({~org[i][31], org[i][30:0]}),
                              .o_y(dif[i]));
        pscrt_fmul u_mul_scl (.i_clk, .i_a(dif[i]), .i_b(scl[i]), .o_y(vec[i]));

        // cross product q x v
        pscrt_fmul u_mul_qva (.i_clk, .i_a(qv[J]), .i_b(vec[K]), .o_y(qva[i]));
        pscrt_fmul u_mul_qvb (.i_clk, .i_a(qv[K]), .i_b(vec[J]), .o_y(qvb[i]));
        pscrt_fadd u_sub_crs (.i_clk, .i_a(qva[i]), .i_b({~qvb[i][31], qvb[i][30:0]}),
                              .o_y(crs[i]));
        pscrt_fmul u_mul_two (.i_clk, .i_a(FP_TWO), .i_b(crs[i]), .o_y(tv[i]));

        // w t and q x t
        pscrt_fmul u_mul_wt  (.i_clk, .i_a(qw), .i_b(tv[i]), .o_y(wt[i]));
        pscrt_fmul u_mul_qta (.i_clk, .i_a(qv[J]), .i_b(tv[K]), .o_y(qta[i]));
        pscrt_fmul u_mul_qtb (.i_clk, .i_a(qv[K]), .i_b(tv[J]), .o_y(qtb[i]));
        pscrt_fadd u_add_vwt (.i_clk, .i_a(r_vd[V_TAP_ADD][32*i +: 32]), .i_b(wt[i]),
                              .o_y(sa[i]));
        pscrt_fadd u_sub_qt  (.i_clk, .i_a(qta[i]), .i_b({~qtb[i][31], qtb[i][30:0]}),
                              .o_y(sb[i]));
        pscrt_fadd u_add_rot (.i_clk, .i_a(sa[i]), .i_b(sb[i]), .o_y(rv[i]));

        // rotate bypass and translate
        assign pre[i] = rot_en ? rv[i] : r_vd[V_TAP_OUT][32*i +: 32];
        pscrt_fadd u_add_shf (.i_clk, .i_a(pre[i]), .i_b(shf[i]), .o_y(res[i]));
    end

    // valid, tag and end flag travel alongside the datapath
    logic            r_vld [LAT];
    logic [KEEP-1:0] r_tag [LAT];
    logic            r_end [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < LAT; n++) begin
                r_vld[n] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept;
            for (int n = 1; n < LAT; n++) begin
                r_vld[n] <= r_vld[n - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_point_tag[KEEP-1:0];
        r_end[0] <= i_batch_end;
        for (int n = 1; n < LAT; n++) begin
            r_tag[n] <= r_tag[n - 1];
            r_end[n] <= r_end[n - 1];
        end
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_placed_x   = res[0];
    assign o_placed_y   = res[1];
    assign o_placed_z   = res[2];
    assign o_result_tag = 16'(r_tag[LAT-1]);
    assign o_result_end = r_end[LAT-1];

    // a result only appears for an item that was offered with start high
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching item");

    // tag and flag stay aligned with their item
    a_tag_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_tag[KEEP-1:0] == $past(i_point_tag[KEEP-1:0], LAT))
                    && (o_result_end == $past(i_batch_end, LAT)))
        else $error("tag or end flag out of step with its item");

    // every nan on x leaves in canonical form
    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_placed_x[30:23] == 8'hFF) && (o_placed_x[22:0] != 23'd0))
        |-> (o_placed_x == FP_QNAN))
        else $error("non canonical nan on x");

endmodule

>>> tb/sv/point_scale_rotate_translate_unit_tb.sv
// self-checking testbench for the point scale, rotate and translate unit
`timescale 1ns / 1ps

module point_scale_rotate_translate_unit_tb;
    import pscrt_pkg::*;

    // register index past the end of the register file, writes to it are dropped
    localparam logic [2:0] REG_UNUSED = 3'(NUM_REGS);
    localparam logic [31:0] FP_ONE = 32'h3F800000;
    localparam logic [31:0] FP_POS_INF = 32'h7F800000;
    localparam int PIPE_DRAIN = 40;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] tag;
        logic        last;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic [31:0] i_point_x = '0;
    logic [31:0] i_point_y = '0;
    logic [31:0] i_point_z = '0;
    logic [15:0] i_point_tag = '0;
    logic        i_batch_end = 1'b0;
    logic        o_valid;
    logic [31:0] o_placed_x;
    logic [31:0] o_placed_y;
    logic [31:0] o_placed_z;
    logic [15:0] o_result_tag;
    logic        o_result_end;

    point_scale_rotate_translate_unit #(.TAG_BITS(16)) dut (.*);

    // testbench copy of the register file
    t_reg_file cfg_regs = REG_RESET;

    t_point points_waiting[$];  // items not yet taken by the unit
    t_point placed_due[$];      // placed points still to come out
    int     error_count = 0;
    bit     idle_enable = 1'b1;
    int     gap_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // single precision arithmetic carried out in double precision;
    // double is wide enough that one rounding back to single is exact
    // ---------------------------------------------------------------
    function automatic real widen(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        real         r;
        e = b[30:23];
        m = b[22:0];
        if (e == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, m, 29'd0});
        if (e == 8'd0) begin
            if (m == 23'd0)
                return $bitstoreal({b[31], 63'd0});
            // subnormal: m times 2^-149
            r = real'(m) * $bitstoreal(64'h36A0000000000000);
            return b[31] ? -r : r;
        end
        return $bitstoreal({b[31], 11'(int'(e) + 896), m, 29'd0});
    endfunction

    // round to nearest even back to single, subnormals kept
    function automatic logic [31:0] narrow(input real x);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic        s;
        int          e;
        int          sh;
        d = $realtobits(x);
        s = d[63];
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? FP_QNAN : {s, FP_POS_INF[30:0]};
        if (d[62:52] == 11'd0)
            return {s, 31'd0};
        e = int'(d[62:52]) - 1023;
        if (e > 127)
            return {s, FP_POS_INF[30:0]};
        sig = {11'd0, 1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 63)
            sh = 63;
        mant = sig >> sh;
        rem = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && mant[0]))
            mant = mant + 64'd1;
        if (e >= -126) begin
            if (mant[24]) begin
                mant = mant >> 1;
                e++;
            end
            if (e > 127)
                return {s, FP_POS_INF[30:0]};
            return {s, 8'(e + 127), mant[22:0]};
        end
        // a carry into bit 23 lands in the exponent field as the smallest normal
        return {s, mant[30:0]};
    endfunction

    function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
        return narrow(widen(a) + widen(b));
    endfunction

    function automatic logic [31:0] sp_sub(input logic [31:0] a, input logic [31:0] b);
        return narrow(widen(a) - widen(b));
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        return narrow(widen(a) * widen(b));
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] f);
        return (f[30:23] == 8'hFF && f[22:0] != 0) ? FP_QNAN : f;
    endfunction

    // placed point for one input item under the current registers
    function automatic t_point place_point(input t_point p);
        logic [31:0] qw, qx, qy, qz;
        logic [31:0] v0, v1, v2, tx, ty, tz, r0, r1, r2;
        t_point      res;
        qw = cfg_regs[REG_SHIFT_Z_QW][63:32];
        qx = cfg_regs[REG_QUAT_XY][31:0];
        qy = cfg_regs[REG_QUAT_XY][63:32];
        qz = cfg_regs[REG_QUAT_Z_ROT][31:0];
        // origin subtract then per-axis scale
        v0 = sp_mul(sp_sub(p.x, cfg_regs[REG_ORIGIN_XY][31:0]), cfg_regs[REG_ORIGIN_Z_SX][63:32]);
        v1 = sp_mul(sp_sub(p.y, cfg_regs[REG_ORIGIN_XY][63:32]), cfg_regs[REG_SCALE_YZ][31:0]);
        v2 = sp_mul(sp_sub(p.z, cfg_regs[REG_ORIGIN_Z_SX][31:0]), cfg_regs[REG_SCALE_YZ][63:32]);
        r0 = v0;
        r1 = v1;
        r2 = v2;
        if (cfg_regs[REG_QUAT_Z_ROT][32]) begin
            // t = 2 (q x v), then r = v + w t + q x t
            tx = sp_mul(FP_TWO, sp_sub(sp_mul(qy, v2), sp_mul(qz, v1)));
            ty = sp_mul(FP_TWO, sp_sub(sp_mul(qz, v0), sp_mul(qx, v2)));
            tz = sp_mul(FP_TWO, sp_sub(sp_mul(qx, v1), sp_mul(qy, v0)));
            r0 = sp_add(sp_add(v0, sp_mul(qw, tx)), sp_sub(sp_mul(qy, tz), sp_mul(qz, ty)));
            r1 = sp_add(sp_add(v1, sp_mul(qw, ty)), sp_sub(sp_mul(qz, tx), sp_mul(qx, tz)));
            r2 = sp_add(sp_add(v2, sp_mul(qw, tz)), sp_sub(sp_mul(qx, ty), sp_mul(qy, tx)));
        end
        res.x = canon(sp_add(r0, cfg_regs[REG_SHIFT_XY][31:0]));
        res.y = canon(sp_add(r1, cfg_regs[REG_SHIFT_XY][63:32]));
        res.z = canon(sp_add(r2, cfg_regs[REG_SHIFT_Z_QW][31:0]));
        res.tag = p.tag;
        res.last = p.last;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // value generators
    // ---------------------------------------------------------------
    function automatic logic [31:0] special_float();
        logic [31:0] pick;
        case ($urandom_range(0, 11))
            0: pick = 32'h00000000;
            1: pick = 32'h80000000;
            2: pick = FP_POS_INF;
            3: pick = 32'hFF800000;
            4: pick = FP_QNAN;
            5: pick = {$urandom_range(0, 1) == 1, 8'hFF, 1'b0, 22'($urandom_range(1, 4194303))};
            6: pick = {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
            7: pick = {$urandom_range(0, 1) == 1, 31'h7F7FFFFF};
            8: pick = {$urandom_range(0, 1) == 1, 31'h00800000};
            9: pick = {$urandom_range(0, 1) == 1, 8'(  $urandom_range(1, 12)), 23'($urandom)};
            10: pick = {$urandom_range(0, 1) == 1, 8'($urandom_range(240, 254)), 23'($urandom)};
            default: pick = FP_ONE;
        endcase
        return pick;
    endfunction

    function automatic logic [31:0] plain_float();
        return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 134)), 23'($urandom)};
    endfunction

    function automatic logic [31:0] any_float();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return plain_float();
        if (k < 8)
            return special_float();
        return $urandom;
    endfunction

    task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.tag = 16'($urandom);
        p.last = 1'($urandom);
        points_waiting.push_back(p);
    endtask

    task automatic add_random_points(input int n);
        for (int i = 0; i < n; i++)
            add_point(any_float(), any_float(), any_float());
    endtask

    // ---------------------------------------------------------------
    // register writes, only issued with the pipeline empty
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx < 3'(NUM_REGS))
            cfg_regs[idx] = (idx == REG_QUAT_Z_ROT) ? (data & QZ_ROT_MASK) : data;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // kind 0 plain values, 1 special values, 2 raw bits
    task automatic write_all_regs(input int kind, input bit rotate);
        logic [63:0] w;
        for (int i = 0; i < NUM_REGS; i++) begin
            case (kind)
                0: w = {plain_float(), plain_float()};
                1: w = {special_float(), special_float()};
                default: w = {$urandom, $urandom};
            endcase
            // random junk above bit 32 of the last register must be dropped
            if (i == NUM_REGS - 1)
                w = {31'($urandom), rotate, w[31:0]};
            write_reg(3'(i), w);
        end
        end_writes();
    endtask

    // wait until every item has gone in and every placed point has come out
    task automatic drain();
        do
            @(negedge i_clk);
        while (points_waiting.size() != 0 || placed_due.size() != 0);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // driver: presents the oldest pending item, with random idle bursts
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // item taken at this edge
            if (start && !busy) begin
                placed_due.push_back(place_point(points_waiting.pop_front()));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (points_waiting.size() == 0) begin
                start <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                gap_left <= $urandom_range(0, 17);
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_point_x <= points_waiting[0].x;
                i_point_y <= points_waiting[0].y;
                i_point_z <= points_waiting[0].z;
                i_point_tag <= points_waiting[0].tag;
                i_batch_end <= points_waiting[0].last;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: every strobe must match the oldest placed point due
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_valid) begin
            if (placed_due.size() == 0) begin
                report_mismatch("unexpected result, tag", 32'(o_result_tag), 32'd0);
            end else begin
                want = placed_due.pop_front();
                if (o_placed_x !== want.x) report_mismatch("placed_x", o_placed_x, want.x);
                if (o_placed_y !== want.y) report_mismatch("placed_y", o_placed_y, want.y);
                if (o_placed_z !== want.z) report_mismatch("placed_z", o_placed_z, want.z);
                if (o_result_tag !== want.tag)
                    report_mismatch("result_tag", 32'(o_result_tag), 32'(want.tag));
                if (o_result_end !== want.last)
                    report_mismatch("result_end", 32'(o_result_end), 32'(want.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // phases: reset registers, then a series of register settings
    // ---------------------------------------------------------------
    initial begin
        logic [31:0] edge_vals [12];
        edge_vals = '{32'h00000000, 32'h80000000, FP_POS_INF, 32'hFF800000, FP_QNAN,
                      32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF,
                      32'hFF7FFFFF, 32'h00800000, FP_ONE};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: field extremes and the special values
        for (int i = 0; i < 12; i++)
            add_point(edge_vals[i], edge_vals[(i + 4) % 12], edge_vals[(i + 7) % 12]);
        points_waiting[0].tag = 16'h0000;
        points_waiting[0].last = 1'b0;
        points_waiting[1].tag = 16'hFFFF;
        points_waiting[1].last = 1'b1;
        add_random_points(180);
        drain();

        // rotation on with an identity quaternion, plus a dropped write
        write_reg(REG_QUAT_Z_ROT, {31'h7FFFFFFF, 1'b1, 32'h00000000});
        write_reg(REG_UNUSED, {$urandom, $urandom});
        end_writes();
        for (int i = 0; i < 12; i++)
            add_point(edge_vals[i], edge_vals[11 - i], plain_float());
        add_random_points(180);
        drain();

        // plain values, rotation on
        write_all_regs(0, 1'b1);
        add_random_points(220);
        drain();

        // every register bit set
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(3'(i), 64'hFFFFFFFFFFFFFFFF);
        end_writes();
        add_random_points(100);
        drain();

        // every register cleared
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(3'(i), 64'h0);
        end_writes();
        add_random_points(100);
        drain();

        // special values, rotation on and off
        write_all_regs(1, 1'b1);
        add_random_points(150);
        drain();
        write_all_regs(1, 1'b0);
        add_random_points(150);
        drain();

        // raw register bits
        write_all_regs(2, 1'b1);
        add_random_points(150);
        drain();

        // plain values, rotation off
        write_all_regs(0, 1'b0);
        add_random_points(200);
        drain();

        // last stretch back to back, no idle bursts
        write_all_regs(0, 1'b1);
        idle_enable = 1'b0;
        add_random_points(250);
        drain();

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
